/* rtl/efq_pkg.sv */
package efq_pkg;

   // Default geometry of the frame ring.
   localparam int SLOTS_DEFAULT      = 8;
   localparam int SLOT_BYTES_DEFAULT = 2048;

   // Field widths of the request and response transactions.
   localparam int CMD_W     = 2;
   localparam int BYTE_W    = 8;
   localparam int OFFSET_W  = 11;
   localparam int MAXLEN_W  = 12;
   localparam int FLEN_W    = 12;
   localparam int STATUS_W  = 2;
   localparam int QUEUED_W  = 4;
   localparam int ETYPE_W   = 16;

   // Frame rules.
   localparam int MIN_FRAME         = 14;
   localparam int ETYPE_HI_POS      = 12;
   localparam int ETYPE_LO_POS      = 13;
   localparam logic [ETYPE_W-1:0] ETYPE_RESET = 16'h88A4;

   typedef enum logic [CMD_W-1:0] {
      CMD_RX      = 2'd0,
      CMD_READ    = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_NONE    = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_KEPT    = 2'd2,
      STAT_DROPPED = 2'd3
   } status_type;

   // Memory strobes from the queue control to the storage.
   typedef struct packed {
      logic frame_wr;
      logic len_wr;
      logic rd;
   } mem_ctl_type;

   // What the queue control decided for one transaction.
   typedef struct packed {
      status_type          status;
      logic                data_en;
      logic                len_en;
      logic [QUEUED_W-1:0] queued;
   } res_info_type;

endpackage

/* rtl/efq_store.sv */
module efq_store #(
   parameter int SLOTS      = efq_pkg::SLOTS_DEFAULT,
   parameter int SLOT_BYTES = efq_pkg::SLOT_BYTES_DEFAULT,
   parameter int SLOT_W     = $clog2(SLOTS),
   parameter int POS_W      = $clog2(SLOT_BYTES + 1),
   parameter int ADDR_W     = $clog2(SLOTS * SLOT_BYTES)
) (
   input  logic                      clock,
   input  efq_pkg::mem_ctl_type      mem_ctl,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [efq_pkg::BYTE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]         rd_addr,
   input  logic [SLOT_W-1:0]         len_wr_slot,
   input  logic [POS_W-1:0]          len_wr_data,
   input  logic [SLOT_W-1:0]         len_rd_slot,
   output logic [efq_pkg::BYTE_W-1:0] rd_byte,
   output logic [POS_W-1:0]          rd_len
);

   logic [efq_pkg::BYTE_W-1:0] frame_mem [SLOTS * SLOT_BYTES];
   logic [POS_W-1:0]           len_mem [SLOTS];
   logic [efq_pkg::BYTE_W-1:0] rd_byte_ff;
   logic [POS_W-1:0]           rd_len_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.frame_wr) begin
         frame_mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd) begin
         rd_byte_ff <= frame_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.len_wr) begin
         len_mem[len_wr_slot] <= len_wr_data;
      end
      if (mem_ctl.rd) begin
         rd_len_ff <= len_mem[len_rd_slot];
      end
   end

   assign rd_byte = rd_byte_ff;
   assign rd_len  = rd_len_ff;

endmodule

/* rtl/efq_ctrl.sv */
module efq_ctrl #(
   parameter int SLOTS      = efq_pkg::SLOTS_DEFAULT,
   parameter int SLOT_BYTES = efq_pkg::SLOT_BYTES_DEFAULT,
   parameter int SLOT_W     = $clog2(SLOTS),
   parameter int POS_W      = $clog2(SLOT_BYTES + 1),
   parameter int ADDR_W     = $clog2(SLOTS * SLOT_BYTES)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [efq_pkg::CMD_W-1:0]    cmd,
   input  logic [efq_pkg::BYTE_W-1:0]   rx_byte,
   input  logic                         rx_last,
   input  logic [efq_pkg::OFFSET_W-1:0] read_offset,
   input  logic                         csr_write,
   input  logic [efq_pkg::ETYPE_W-1:0]  csr_value,
   output efq_pkg::mem_ctl_type         mem_ctl,
   output logic [ADDR_W-1:0]            wr_addr,
   output logic [ADDR_W-1:0]            rd_addr,
   output logic [SLOT_W-1:0]            len_wr_slot,
   output logic [POS_W-1:0]             len_wr_data,
   output logic [SLOT_W-1:0]            len_rd_slot,
   output efq_pkg::res_info_type        res
);

   localparam int CNT_W = $clog2(SLOTS + 1);

   logic [SLOT_W-1:0]          head_ff, head_in;
   logic [SLOT_W-1:0]          tail_ff, tail_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [POS_W-1:0]           rx_count_ff, rx_count_in;
   logic                       high_ok_ff, high_ok_in;
   logic                       match_ff, match_in;
   logic                       overlong_ff, overlong_in;
   logic                       blocked_ff, blocked_in;
   logic [efq_pkg::ETYPE_W-1:0] etype_ff;

   logic             full;
   logic             empty;
   logic [POS_W-1:0] cnt_v;
   logic             high_v;
   logic             match_v;
   logic             overlong_v;
   logic             blocked_v;
   logic             keep;

   assign full  = (count_ff == CNT_W'(SLOTS));
   assign empty = (count_ff == '0);

   // Byte addresses: slot base plus position within the slot. A read offset
   // past the slot only ever lands on bytes that the length check discards.
   assign wr_addr = ADDR_W'(tail_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(rx_count_ff);
   assign rd_addr = ADDR_W'(head_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(read_offset);
   assign len_wr_slot = tail_ff;
   assign len_rd_slot = head_ff;
   assign len_wr_data = cnt_v;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      rx_count_in = rx_count_ff;
      high_ok_in  = high_ok_ff;
      match_in    = match_ff;
      overlong_in = overlong_ff;
      blocked_in  = blocked_ff;
      cnt_v       = rx_count_ff;
      high_v      = high_ok_ff;
      match_v     = match_ff;
      overlong_v  = overlong_ff;
      blocked_v   = blocked_ff;
      keep        = 1'b0;
      mem_ctl.frame_wr = 1'b0;
      mem_ctl.len_wr   = 1'b0;
      mem_ctl.rd       = step;
      res.status  = efq_pkg::STAT_NONE;
      res.data_en = 1'b0;
      res.len_en  = 1'b0;
      if (step) begin
         unique case (efq_pkg::cmd_type'(cmd)) inside
            efq_pkg::CMD_RX: begin
               blocked_v = blocked_ff | full;
               if (rx_count_ff >= POS_W'(SLOT_BYTES)) begin
                  overlong_v = 1'b1;
               end else begin
                  mem_ctl.frame_wr = !full;
                  if (rx_count_ff == POS_W'(efq_pkg::ETYPE_HI_POS)) begin
                     high_v = (rx_byte == etype_ff[15:8]);
                  end
                  if (rx_count_ff == POS_W'(efq_pkg::ETYPE_LO_POS)) begin
                     match_v = high_ok_ff && (rx_byte == etype_ff[7:0]);
                  end
                  cnt_v = rx_count_ff + 1'b1;
               end
               if (rx_last) begin
                  keep = (cnt_v >= POS_W'(efq_pkg::MIN_FRAME)) && match_v &&
                         !overlong_v && !blocked_v && !full;
                  if (keep) begin
                     mem_ctl.len_wr = 1'b1;
                     tail_in  = (tail_ff == SLOT_W'(SLOTS - 1)) ? '0 : tail_ff + 1'b1;
                     count_in = count_ff + 1'b1;
                     res.status = efq_pkg::STAT_KEPT;
                  end else begin
                     res.status = efq_pkg::STAT_DROPPED;
                  end
                  rx_count_in = '0;
                  high_ok_in  = 1'b0;
                  match_in    = 1'b0;
                  overlong_in = 1'b0;
                  blocked_in  = 1'b0;
               end else begin
                  rx_count_in = cnt_v;
                  high_ok_in  = high_v;
                  match_in    = match_v;
                  overlong_in = overlong_v;
                  blocked_in  = blocked_v;
               end
            end
            efq_pkg::CMD_READ, efq_pkg::CMD_RELEASE: begin
               if (empty) begin
                  res.status = efq_pkg::STAT_EMPTY;
               end else begin
                  res.len_en = 1'b1;
                  if (efq_pkg::cmd_type'(cmd) == efq_pkg::CMD_READ) begin
                     res.data_en = 1'b1;
                  end else begin
                     head_in  = (head_ff == SLOT_W'(SLOTS - 1)) ? '0 : head_ff + 1'b1;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            default: begin
               res.status = efq_pkg::STAT_NONE;
            end
         endcase
      end
      res.queued = efq_pkg::QUEUED_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         rx_count_ff <= '0;
         high_ok_ff  <= 1'b0;
         match_ff    <= 1'b0;
         overlong_ff <= 1'b0;
         blocked_ff  <= 1'b0;
         etype_ff    <= efq_pkg::ETYPE_RESET;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         rx_count_ff <= rx_count_in;
         high_ok_ff  <= high_ok_in;
         match_ff    <= match_in;
         overlong_ff <= overlong_in;
         blocked_ff  <= blocked_in;
         if (csr_write) begin
            etype_ff <= csr_value;
         end
      end
   end

endmodule

/* rtl/ethertype_filtered_frame_queue.sv */
// Receive frame queue with an EtherType filter. Each request transaction is
// one of three commands in req_tuser: receive one frame byte (req_tlast marks
// the final byte), read one byte of the oldest queued frame, or release the
// oldest frame. A frame is kept when it is at least 14 bytes long, carries the
// EtherType written through the csr port (reset value 0x88A4) in bytes 12 and
// 13, fits in one slot of SLOT_BYTES bytes and found the ring of SLOTS slots
// not full for any of its bytes; otherwise it is dropped when its last byte
// arrives. Every request gives exactly one response transaction. The block
// takes one request per clock cycle when the response side keeps up: a
// request is held in the input register, the queue state and both
// memories are updated as it moves to the response register, and
// rsp_tvalid rises once it sits in the response register. The frame
// bytes sit in a single memory with one write port and one registered
// read port and the lengths in a second memory; neither needs a clearing
// pass after reset.
module ethertype_filtered_frame_queue #(
   parameter int SLOTS      = efq_pkg::SLOTS_DEFAULT,
   parameter int SLOT_BYTES = efq_pkg::SLOT_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] rx_byte, [18:8] read_offset, [30:19] max_len, [31] zero
   input  logic [31:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]  req_tuser,
   // rx_last
   input  logic        req_tlast,

   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [19:8] frame_len, [23:20] queued_frames
   output logic [23:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser,

   // EtherType register write port.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int POS_W  = $clog2(SLOT_BYTES + 1);
   localparam int ADDR_W = $clog2(SLOTS * SLOT_BYTES);
   localparam int CMP_W  = (POS_W > efq_pkg::FLEN_W) ? POS_W : efq_pkg::FLEN_W;

   // Input register.
   logic                          in_valid_ff, in_valid_in;
   logic [efq_pkg::CMD_W-1:0]     in_cmd_ff;
   logic [efq_pkg::BYTE_W-1:0]    in_byte_ff;
   logic                          in_last_ff;
   logic [efq_pkg::OFFSET_W-1:0]  in_offset_ff;
   logic [efq_pkg::MAXLEN_W-1:0]  in_max_len_ff;

   // Response register; the memory read data registers sit beside it.
   logic                          out_valid_ff, out_valid_in;
   efq_pkg::res_info_type         out_info_ff;
   logic [efq_pkg::OFFSET_W-1:0]  out_offset_ff;
   logic [efq_pkg::MAXLEN_W-1:0]  out_max_len_ff;

   logic                          req_accept;
   logic                          step;
   efq_pkg::mem_ctl_type          mem_ctl;
   efq_pkg::res_info_type         res;
   logic [ADDR_W-1:0]             wr_addr;
   logic [ADDR_W-1:0]             rd_addr;
   logic [SLOT_W-1:0]             len_wr_slot;
   logic [POS_W-1:0]              len_wr_data;
   logic [SLOT_W-1:0]             len_rd_slot;
   logic [efq_pkg::BYTE_W-1:0]    rd_byte;
   logic [POS_W-1:0]              rd_len;
   logic [CMP_W-1:0]              clip_len;
   logic [efq_pkg::FLEN_W-1:0]    frame_len;
   logic [efq_pkg::BYTE_W-1:0]    read_data;

   // The held request advances whenever the response register is free or is
   // being emptied in this cycle, so a new request can enter every cycle while rsp_tready stays high.
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_accept || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff     <= req_tuser;
         in_byte_ff    <= req_tdata[7:0];
         in_last_ff    <= req_tlast;
         in_offset_ff  <= req_tdata[18:8];
         in_max_len_ff <= req_tdata[30:19];
      end
      if (step) begin
         out_info_ff    <= res;
         out_offset_ff  <= in_offset_ff;
         out_max_len_ff <= in_max_len_ff;
      end
   end

   efq_ctrl #(
      .SLOTS      (SLOTS),
      .SLOT_BYTES (SLOT_BYTES),
      .SLOT_W     (SLOT_W),
      .POS_W      (POS_W),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .cmd         (in_cmd_ff),
      .rx_byte     (in_byte_ff),
      .rx_last     (in_last_ff),
      .read_offset (in_offset_ff),
      .csr_write   (csr_valid),
      .csr_value   (csr_wdata),
      .mem_ctl     (mem_ctl),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .len_wr_slot (len_wr_slot),
      .len_wr_data (len_wr_data),
      .len_rd_slot (len_rd_slot),
      .res         (res)
   );

   efq_store #(
      .SLOTS      (SLOTS),
      .SLOT_BYTES (SLOT_BYTES),
      .SLOT_W     (SLOT_W),
      .POS_W      (POS_W),
      .ADDR_W     (ADDR_W)
   ) u_store (
      .clock       (clock),
      .mem_ctl     (mem_ctl),
      .wr_addr     (wr_addr),
      .wr_data     (in_byte_ff),
      .rd_addr     (rd_addr),
      .len_wr_slot (len_wr_slot),
      .len_wr_data (len_wr_data),
      .len_rd_slot (len_rd_slot),
      .rd_byte     (rd_byte),
      .rd_len      (rd_len)
   );

   // The stored length and byte arrive from the memory read registers; the
   // length is clipped to the caller's buffer size and bytes past the clipped
   // length read as zero. Both are zero unless the queue held a frame.
   always_comb begin
      clip_len = (CMP_W'(rd_len) > CMP_W'(out_max_len_ff)) ?
                 CMP_W'(out_max_len_ff) : CMP_W'(rd_len);
      frame_len = '0;
      read_data = '0;
      if (out_info_ff.len_en) begin
         frame_len = efq_pkg::FLEN_W'(clip_len);
      end
      if (out_info_ff.data_en && (CMP_W'(out_offset_ff) < clip_len)) begin
         read_data = rd_byte;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_info_ff.queued, frame_len, read_data};
   assign rsp_tuser  = out_info_ff.status;

endmodule

/* tb/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_SLOTS = efq_pkg::SLOTS_DEFAULT;
   localparam int SLOT_SIZE = efq_pkg::SLOT_BYTES_DEFAULT;
   // Command code 3 has no meaning; the block must answer it with status none and zero data and length.
   localparam logic [efq_pkg::CMD_W-1:0] CMD_IGNORED = 2'd3;
   localparam int PHASES = 5;
   localparam int PHASE_ITEMS = 345;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AT = 200;
   localparam int HOLD_CYCLES = 100;
   localparam int DRAIN_CYCLES = 8;
   localparam int DIRECTED_ROWS = 24;

   typedef struct packed {
      logic [efq_pkg::CMD_W-1:0]    cmd;
      logic [efq_pkg::BYTE_W-1:0]   octet;
      logic                         last;
      logic [efq_pkg::OFFSET_W-1:0] offset;
      logic [efq_pkg::MAXLEN_W-1:0] max_len;
   } frame_req_type;

   typedef struct packed {
      logic [efq_pkg::BYTE_W-1:0]   read_data;
      logic [efq_pkg::FLEN_W-1:0]   frame_len;
      efq_pkg::status_type          status;
      logic [efq_pkg::QUEUED_W-1:0] queued;
   } frame_rsp_type;

   // One directed row; when typed is set, rsp is the response to expect.
   typedef struct packed {
      frame_req_type req;
      logic          typed;
      frame_rsp_type rsp;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = efq_pkg::CMD_RX;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = '0;

   ethertype_filtered_frame_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the frame ring and of the receive state.
   logic [7:0]  shadow_bytes [RING_SLOTS*SLOT_SIZE];
   int          shadow_len [RING_SLOTS];
   int          head_slot = 0;
   int          tail_slot = 0;
   bit          ring_full = 0;
   int          rx_pos = 0;
   bit          hi_ok = 0;
   bit          type_ok = 0;
   bit          overlong = 0;
   bit          blocked = 0;
   logic [15:0] ethertype = efq_pkg::ETYPE_RESET;

   frame_rsp_type due_responses[$];
   int          sent_items = 0;
   int          rsp_count = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   // While calm is set the request side never idles and the response side idles only for the long hold-off.
   bit          calm = 0;
   int          hold_left = 0;
   bit          hold_done = 0;
   directed_row_type directed_rows [DIRECTED_ROWS];

   // Advances the shadow queue by one request and returns the response it must give.
   function automatic frame_rsp_type frame_queue_step(frame_req_type r);
      frame_rsp_type o;
      int            pos;
      int            flen;
      o = '0;
      o.status = efq_pkg::STAT_NONE;
      if (r.cmd == efq_pkg::CMD_RX) begin
         pos = rx_pos;
         // A single byte arriving while the ring is full spoils the whole frame.
         if (ring_full) blocked = 1;
         if (pos >= SLOT_SIZE) begin
            overlong = 1;
         end else begin
            if (!ring_full) shadow_bytes[tail_slot*SLOT_SIZE + pos] = r.octet;
            if (pos == efq_pkg::ETYPE_HI_POS) hi_ok = (r.octet == ethertype[15:8]);
            if (pos == efq_pkg::ETYPE_LO_POS) type_ok = hi_ok && (r.octet == ethertype[7:0]);
            rx_pos = pos + 1;
         end
         if (r.last) begin
            if (rx_pos >= efq_pkg::MIN_FRAME && type_ok && !overlong && !blocked &&
                !ring_full) begin
               shadow_len[tail_slot] = rx_pos;
               tail_slot = (tail_slot + 1) % RING_SLOTS;
               if (tail_slot == head_slot) ring_full = 1;
               o.status = efq_pkg::STAT_KEPT;
            end else begin
               o.status = efq_pkg::STAT_DROPPED;
            end
            rx_pos = 0;
            hi_ok = 0;
            type_ok = 0;
            overlong = 0;
            blocked = 0;
         end
      end else if (r.cmd == efq_pkg::CMD_READ || r.cmd == efq_pkg::CMD_RELEASE) begin
         if (!ring_full && head_slot == tail_slot) begin
            o.status = efq_pkg::STAT_EMPTY;
         end else begin
            flen = (shadow_len[head_slot] > int'(r.max_len)) ? int'(r.max_len)
                                                              : shadow_len[head_slot];
            o.frame_len = efq_pkg::FLEN_W'(flen);
            if (r.cmd == efq_pkg::CMD_READ) begin
               if (int'(r.offset) < flen)
                  o.read_data = shadow_bytes[head_slot*SLOT_SIZE + int'(r.offset)];
            end else begin
               head_slot = (head_slot + 1) % RING_SLOTS;
               ring_full = 0;
            end
         end
      end
      o.queued = efq_pkg::QUEUED_W'(ring_full ? RING_SLOTS
                                    : (tail_slot + RING_SLOTS - head_slot) % RING_SLOTS);
      return o;
   endfunction

   function automatic logic [efq_pkg::MAXLEN_W-1:0] pick_max_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return efq_pkg::MAXLEN_W'(SLOT_SIZE);
      if (roll < 90) return efq_pkg::MAXLEN_W'($urandom_range(0, SLOT_SIZE));
      return efq_pkg::MAXLEN_W'($urandom_range(0, 20));
   endfunction

   function automatic frame_req_type random_request(logic [efq_pkg::CMD_W-1:0] cmd);
      frame_req_type r;
      r.cmd = cmd;
      r.octet = efq_pkg::BYTE_W'($urandom);
      r.last = 1'($urandom);
      r.offset = ($urandom_range(0, 99) < 80)
                 ? efq_pkg::OFFSET_W'($urandom_range(0, 63))
                 : efq_pkg::OFFSET_W'($urandom_range(0, SLOT_SIZE - 1));
      r.max_len = pick_max_len();
      return r;
   endfunction

   // Offers one request transaction, waits for it to be taken and records its response.
   task automatic offer_request(frame_req_type r, bit typed = 0,
                                frame_rsp_type typed_rsp = '0);
      frame_rsp_type predicted;
      while (!calm && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.cmd;
      req_tlast <= r.last;
      req_tdata <= {1'b0, r.max_len, r.offset, r.octet};
      do @(posedge clock); while (!req_tready);
      predicted = frame_queue_step(r);
      due_responses.push_back(typed ? typed_rsp : predicted);
      sent_items++;
   endtask

   // Sends a whole frame; reads and releases may be slipped in between its bytes.
   task automatic offer_frame(int len, logic [7:0] type_hi, logic [7:0] type_lo, bit mixed);
      frame_req_type r;
      for (int b = 0; b < len; b++) begin
         if (mixed && b > 0 && $urandom_range(0, 99) < 4)
            offer_request(random_request($urandom_range(0, 1) ? efq_pkg::CMD_READ
                                                              : efq_pkg::CMD_RELEASE));
         r = random_request(efq_pkg::CMD_RX);
         if (b == efq_pkg::ETYPE_HI_POS) r.octet = type_hi;
         if (b == efq_pkg::ETYPE_LO_POS) r.octet = type_lo;
         r.last = (b == len - 1);
         offer_request(r);
      end
   endtask

   // Stops offering and waits until every response is back and the pipeline is quiet.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Response side: checks each transaction, then decides on backpressure for the next cycle.
   always @(posedge clock) begin : rsp_side
      frame_rsp_type got;
      frame_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            got.read_data = rsp_tdata[7:0];
            got.frame_len = rsp_tdata[19:8];
            got.queued = rsp_tdata[23:20];
            got.status = efq_pkg::status_type'(rsp_tuser);
            if (due_responses.size() == 0) begin
               $error("response transaction with none expected");
               mismatches++;
            end else begin
               want = due_responses.pop_front();
               if (got.read_data !== want.read_data) begin
                  $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
                  mismatches++;
               end
               if (got.frame_len !== want.frame_len) begin
                  $error("frame_len: expected %0d, got %0d", want.frame_len, got.frame_len);
                  mismatches++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  mismatches++;
               end
               if (got.queued !== want.queued) begin
                  $error("queued_frames: expected %0d, got %0d", want.queued, got.queued);
                  mismatches++;
               end
            end
         end
         // One long hold-off lets the request side back up until the block stalls its input.
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_count >= HOLD_AT) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || $urandom_range(0, 99) >= 14;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int          roll;
      int          len;
      int          release_pct;
      int          phase_start;
      logic [7:0]  type_hi;
      logic [7:0]  type_lo;
      logic [15:0] setting;

      // Directed rows run against the reset EtherType 0x88A4: empty queue answers,
      // the ignored command, a one-byte frame, then a minimal 14-byte frame that is
      // kept, read at its edges and with clipped lengths, and released.
      directed_rows = '{
         '{'{efq_pkg::CMD_READ,    8'hFF, 1'b1, 11'h7FF, 12'd2048}, 1'b1,
           '{8'h00, 12'd0,  efq_pkg::STAT_EMPTY,   4'd0}},
         '{'{efq_pkg::CMD_RELEASE, 8'h00, 1'b0, 11'h000, 12'd0},    1'b1,
           '{8'h00, 12'd0,  efq_pkg::STAT_EMPTY,   4'd0}},
         '{'{CMD_IGNORED,          8'hFF, 1'b1, 11'h7FF, 12'd2048}, 1'b1,
           '{8'h00, 12'd0,  efq_pkg::STAT_NONE,    4'd0}},
         '{'{efq_pkg::CMD_RX,      8'h5A, 1'b1, 11'h000, 12'd0},    1'b1,
           '{8'h00, 12'd0,  efq_pkg::STAT_DROPPED, 4'd0}},
         '{'{efq_pkg::CMD_RX,      8'h00, 1'b0, 11'h7FF, 12'd2048}, 1'b1,
           '{8'h00, 12'd0,  efq_pkg::STAT_NONE,    4'd0}},
         '{'{efq_pkg::CMD_RX,      8'hFF, 1'b0, 11'h000, 12'd0},    1'b0, '0},
         '{'{efq_pkg::CMD_RX,      8'h11, 1'b0, 11'h155, 12'd1365}, 1'b0, '0},
         '{'{efq_pkg::CMD_RX,      8'h22, 1'b0, 11'h2AA, 12'd2730}, 1'b0, '0},
         '{'{efq_pkg::CMD_RX,      8'h33, 1'b0, 11'h000, 12'd0},    1'b0, '0},
         '{'{efq_pkg::CMD_RX,      8'h44, 1'b0, 11'h000, 12'd0},    1'b0, '0},
         '{'{efq_pkg::CMD_RX,      8'h55, 1'b0, 11'h000, 12'd0},    1'b0, '0},
         '{'{efq_pkg::CMD_RX,      8'h66, 1'b0, 11'h000, 12'd0},    1'b0, '0},
         '{'{efq_pkg::CMD_RX,      8'h77, 1'b0, 11'h000, 12'd0},    1'b0, '0},
         '{'{efq_pkg::CMD_RX,      8'h01, 1'b0, 11'h000, 12'd0},    1'b0, '0},
         '{'{efq_pkg::CMD_RX,      8'h80, 1'b0, 11'h000, 12'd0},    1'b0, '0},
         '{'{efq_pkg::CMD_RX,      8'h7F, 1'b0, 11'h000, 12'd0},    1'b0, '0},
         '{'{efq_pkg::CMD_RX,      8'h88, 1'b0, 11'h000, 12'd0},    1'b1,
           '{8'h00, 12'd0,  efq_pkg::STAT_NONE,    4'd0}},
         '{'{efq_pkg::CMD_RX,      8'hA4, 1'b1, 11'h000, 12'd0},    1'b1,
           '{8'h00, 12'd0,  efq_pkg::STAT_KEPT,    4'd1}},
         '{'{efq_pkg::CMD_READ,    8'h00, 1'b0, 11'd13,  12'd2048}, 1'b1,
           '{8'hA4, 12'd14, efq_pkg::STAT_NONE,    4'd1}},
         '{'{efq_pkg::CMD_READ,    8'h00, 1'b0, 11'd14,  12'd2048}, 1'b1,
           '{8'h00, 12'd14, efq_pkg::STAT_NONE,    4'd1}},
         '{'{efq_pkg::CMD_READ,    8'h00, 1'b0, 11'd0,   12'd0},    1'b1,
           '{8'h00, 12'd0,  efq_pkg::STAT_NONE,    4'd1}},
         '{'{efq_pkg::CMD_READ,    8'h00, 1'b0, 11'd1,   12'd4},    1'b1,
           '{8'hFF, 12'd4,  efq_pkg::STAT_NONE,    4'd1}},
         '{'{efq_pkg::CMD_RELEASE, 8'h00, 1'b0, 11'd0,   12'd2048}, 1'b1,
           '{8'h00, 12'd14, efq_pkg::STAT_NONE,    4'd0}},
         '{'{efq_pkg::CMD_RELEASE, 8'h00, 1'b0, 11'd0,   12'd2048}, 1'b1,
           '{8'h00, 12'd0,  efq_pkg::STAT_EMPTY,   4'd0}}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      for (int phase = 0; phase < PHASES; phase++) begin
         // The EtherType register only changes while nothing is in flight.
         wait_for_drain();
         case (phase)
            0:       setting = efq_pkg::ETYPE_RESET;
            1:       setting = 16'h0000;
            2:       setting = 16'hFFFF;
            default: setting = 16'($urandom);
         endcase
         csr_valid <= 1'b1;
         csr_wdata <= setting;
         do @(posedge clock); while (!csr_ready);
         csr_valid <= 1'b0;
         ethertype = setting;

         // In the first phase neither side idles, but for the long hold-off on the response side.
         calm = (phase == 0);

         // Even phases rarely release, so the ring fills and later frames are refused;
         // odd phases drain it again.
         release_pct = (phase % 2 == 0) ? 6 : 25;
         phase_start = sent_items;
         while (sent_items - phase_start < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               offer_request(random_request(CMD_IGNORED));
            end else if (roll < 3 + release_pct) begin
               offer_request(random_request(efq_pkg::CMD_RELEASE));
            end else if (roll < 23 + release_pct) begin
               offer_request(random_request(efq_pkg::CMD_READ));
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 10) len = $urandom_range(1, efq_pkg::MIN_FRAME - 1);
               else if (roll < 90) len = $urandom_range(efq_pkg::MIN_FRAME, 40);
               else len = $urandom_range(41, 200);
               roll = $urandom_range(0, 99);
               type_hi = ethertype[15:8];
               type_lo = ethertype[7:0];
               if (roll >= 90) begin
                  type_hi = 8'($urandom);
                  type_lo = 8'($urandom);
               end else if (roll >= 75) begin
                  type_lo = ethertype[7:0] ^ (8'h01 << $urandom_range(0, 7));
               end
               offer_frame(len, type_hi, type_lo, 1);
            end
         end
         calm = 0;
      end

      wait_for_drain();
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
rtl/efq_pkg.sv
rtl/efq_store.sv
rtl/efq_ctrl.sv
rtl/ethertype_filtered_frame_queue.sv
tb/tb.sv
